/* src/dbt_pkg.sv */
// Shared types and codes for the debug breakpoint table.
`timescale 1ns / 1ps

package dbt_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_CHECK  = 2'd3
  } cmd_e;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_KIND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // run modes
  localparam logic [2:0] MODE_STEP   = 3'd2;
  localparam logic [2:0] MODE_INIT   = 3'd3;
  localparam logic [2:0] MODE_DETACH = 3'd4;

  // point kinds: up to hw break is a breakpoint, up to access is a watchpoint
  localparam logic [2:0] KIND_LAST_BREAK = 3'd1;
  localparam logic [2:0] KIND_LAST_WATCH = 3'd4;

  // selected_cpu value for "any core"
  localparam logic [4:0] SEL_ANY = 5'h1F;

  // configuration register indexes
  localparam logic REG_RUN_MODE = 1'b0;
  localparam logic REG_SEL_CPU  = 1'b1;

  // watch entry word: {type, end, begin}
  localparam int unsigned WATCH_W = 67;

endpackage

/* src/debug_breakpoint_table.sv */
// Breakpoint / watchpoint table with a shared scan comparator.
`timescale 1ns / 1ps
// Insert, clear-all and mode-decided checks go straight from accept to the done state.
// A check scans the breakpoint list, reading then comparing one entry at a time.
// A remove scans the same way, then moves each later entry down with a read and then a write.
// One word at a time: tready is high only in idle; one comparator serves both lists.
// Reset (async, active low) empties both lists and sets run mode detach, selected core any.

module debug_breakpoint_table
  import dbt_pkg::*;
#(
  parameter int unsigned BREAK_SLOTS = 16,
  parameter int unsigned WATCH_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // address[31:0], length[63:32], core_id[67:64], zero pad
  input  logic [4:0]  s_axis_tuser,  // command[1:0], point_kind[4:2]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status[1:0], stop[2], break_count[7:3],
                                     // watch_count[12:8], zero pad
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i
);

  localparam int unsigned BAW = (BREAK_SLOTS > 1) ? $clog2(BREAK_SLOTS) : 1;
  localparam int unsigned WAW = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;
  localparam int unsigned BCW = $clog2(BREAK_SLOTS + 1);
  localparam int unsigned WCW = $clog2(WATCH_SLOTS + 1);
  localparam int unsigned IW  = (BCW > WCW) ? BCW : WCW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_e;

  // list storage: one write and one registered read per cycle each
  logic [31:0]        brk_mem [BREAK_SLOTS];
  logic [WATCH_W-1:0] wat_mem [WATCH_SLOTS];
  logic [31:0]        brk_rd_q;
  logic [WATCH_W-1:0] wat_rd_q;

  state_e             state_q, state_d;
  cmd_e               cmd_q, cmd_d;
  logic [WATCH_W-1:0] key_q, key_d;
  logic               use_watch_q, use_watch_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [BCW-1:0]     brk_cnt_q, brk_cnt_d;
  logic [WCW-1:0]     wat_cnt_q, wat_cnt_d;
  logic [1:0]         res_status_q, res_status_d;
  logic               res_stop_q, res_stop_d;
  logic               out_valid_q, out_valid_d;
  logic [15:0]        out_data_q, out_data_d;
  logic [2:0]         run_mode_q;
  logic [4:0]         sel_cpu_q;

  // memory port controls
  logic               brk_we, wat_we;
  logic [IW-1:0]      mem_waddr, mem_raddr;
  logic [31:0]        brk_wdata;
  logic [WATCH_W-1:0] wat_wdata;

  // decoded input word
  logic [1:0]  in_cmd;
  logic [2:0]  in_kind;
  logic [31:0] in_addr, in_len;
  logic [3:0]  in_core;
  logic        in_acc;

  // shared scan unit
  logic [WATCH_W-1:0] cmp_opnd;
  logic               cmp_hit;
  logic [IW-1:0]      act_cnt;
  logic [IW-1:0]      idx_p1;
  logic [IW:0]        idx_p2;
  logic               cpu_ok;

  assign in_cmd  = s_axis_tuser[1:0];
  assign in_kind = s_axis_tuser[4:2];
  assign in_addr = s_axis_tdata[31:0];
  assign in_len  = s_axis_tdata[63:32];
  assign in_core = s_axis_tdata[67:64];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign cmp_opnd = use_watch_q ? wat_rd_q : {{(WATCH_W - 32){1'b0}}, brk_rd_q};
  assign cmp_hit  = (cmp_opnd == key_q);
  assign act_cnt  = use_watch_q ? IW'(wat_cnt_q) : IW'(brk_cnt_q);
  assign idx_p1   = idx_q + 1'b1;
  assign idx_p2   = {1'b0, idx_q} + (IW + 1)'(2);

  // core filter; negative selections other than "any" never match
  assign cpu_ok = (sel_cpu_q == SEL_ANY) || ({1'b0, in_core} == sel_cpu_q);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    use_watch_d  = use_watch_q;
    idx_d        = idx_q;
    brk_cnt_d    = brk_cnt_q;
    wat_cnt_d    = wat_cnt_q;
    res_status_d = res_status_q;
    res_stop_d   = res_stop_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    brk_we       = 1'b0;
    wat_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_raddr    = idx_q;
    brk_wdata    = brk_rd_q;
    wat_wdata    = wat_rd_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d        = cmd_e'(in_cmd);
          res_status_d = ST_OK;
          res_stop_d   = 1'b0;
          idx_d        = '0;
          state_d      = S_DONE;
          case (cmd_e'(in_cmd))
            CMD_INSERT: begin
              if (in_kind <= KIND_LAST_BREAK) begin
                if (brk_cnt_q == BCW'(BREAK_SLOTS)) begin
                  res_status_d = ST_FULL;
                end else begin
                  brk_we    = 1'b1;
                  mem_waddr = IW'(brk_cnt_q);
                  brk_wdata = in_addr;
                  brk_cnt_d = brk_cnt_q + 1'b1;
                end
              end else if (in_kind <= KIND_LAST_WATCH) begin
                if (wat_cnt_q == WCW'(WATCH_SLOTS)) begin
                  res_status_d = ST_FULL;
                end else begin
                  wat_we    = 1'b1;
                  mem_waddr = IW'(wat_cnt_q);
                  wat_wdata = {in_kind, in_addr + in_len, in_addr};
                  wat_cnt_d = wat_cnt_q + 1'b1;
                end
              end else begin
                res_status_d = ST_BAD_KIND;
              end
            end
            CMD_REMOVE: begin
              if (in_kind <= KIND_LAST_BREAK) begin
                use_watch_d = 1'b0;
                key_d       = {{(WATCH_W - 32){1'b0}}, in_addr};
                if (brk_cnt_q != '0) state_d = S_RD;
              end else if (in_kind <= KIND_LAST_WATCH) begin
                use_watch_d = 1'b1;
                key_d       = {in_kind, in_addr + in_len, in_addr};
                if (wat_cnt_q != '0) state_d = S_RD;
              end else begin
                res_status_d = ST_BAD_KIND;
              end
            end
            CMD_CLEAR: begin
              brk_cnt_d = '0;
              wat_cnt_d = '0;
            end
            CMD_CHECK: begin
              use_watch_d = 1'b0;
              key_d       = {{(WATCH_W - 32){1'b0}}, in_addr};
              if (run_mode_q == MODE_DETACH || !cpu_ok) begin
                res_stop_d = 1'b0;
              end else if (run_mode_q == MODE_STEP || run_mode_q == MODE_INIT) begin
                res_stop_d = 1'b1;
              end else if (brk_cnt_q != '0) begin
                state_d = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        mem_raddr = idx_q;
        state_d   = S_CMP;
      end
      S_CMP: begin
        if (cmp_hit) begin
          if (cmd_q == CMD_CHECK) begin
            res_stop_d = 1'b1;
            state_d    = S_DONE;
          end else if (idx_p1 < act_cnt) begin
            state_d = S_SH_RD;
          end else begin
            if (use_watch_q) wat_cnt_d = wat_cnt_q - 1'b1;
            else brk_cnt_d = brk_cnt_q - 1'b1;
            state_d = S_DONE;
          end
        end else if (idx_p1 == act_cnt) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_p1;
          state_d = S_RD;
        end
      end
      S_SH_RD: begin
        // fetch the entry above the gap
        mem_raddr = idx_p1;
        state_d   = S_SH_WR;
      end
      S_SH_WR: begin
        mem_waddr = idx_q;
        brk_wdata = brk_rd_q;
        wat_wdata = wat_rd_q;
        if (use_watch_q) wat_we = 1'b1;
        else brk_we = 1'b1;
        idx_d = idx_p1;
        if (idx_p2 < {1'b0, act_cnt}) begin
          state_d = S_SH_RD;
        end else begin
          if (use_watch_q) wat_cnt_d = wat_cnt_q - 1'b1;
          else brk_cnt_d = brk_cnt_q - 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {3'b000, 5'(wat_cnt_q), 5'(brk_cnt_q), res_stop_q, res_status_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= CMD_INSERT;
      use_watch_q  <= 1'b0;
      idx_q        <= '0;
      brk_cnt_q    <= '0;
      wat_cnt_q    <= '0;
      res_status_q <= ST_OK;
      res_stop_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      run_mode_q   <= MODE_DETACH;
      sel_cpu_q    <= SEL_ANY;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      use_watch_q  <= use_watch_d;
      idx_q        <= idx_d;
      brk_cnt_q    <= brk_cnt_d;
      wat_cnt_q    <= wat_cnt_d;
      res_status_q <= res_status_d;
      res_stop_q   <= res_stop_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RUN_MODE: run_mode_q <= cfg_data_i[2:0];
          REG_SEL_CPU:  sel_cpu_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (brk_we) brk_mem[mem_waddr[BAW-1:0]] <= brk_wdata;
    brk_rd_q <= brk_mem[mem_raddr[BAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wat_we) wat_mem[mem_waddr[WAW-1:0]] <= wat_wdata;
    wat_rd_q <= wat_mem[mem_raddr[WAW-1:0]];
  end

endmodule

/* src/dbt_checker.sv */
// Port-level checks for the debug breakpoint table, bound to the top level.
`timescale 1ns / 1ps

module dbt_checker
  import dbt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // one word at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in work");

  // a halt only comes with ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == ST_OK)
    else $error("stop with non-ok status");

  // status never carries the unused code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("invalid status code");

endmodule

bind debug_breakpoint_table dbt_checker u_dbt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/debug_breakpoint_table_tb.sv */
// Stream testbench for the debug breakpoint table: directed and random words, self-checking.
`timescale 1ns / 1ps

module debug_breakpoint_table_tb;
  import dbt_pkg::*;

  // point kinds, run modes and sizes as seen from the stream side
  localparam logic [2:0] KIND_SW_BREAK  = 3'd0;
  localparam logic [2:0] KIND_HW_BREAK  = 3'd1;
  localparam logic [2:0] KIND_WRITE     = 3'd2;
  localparam logic [2:0] KIND_READ      = 3'd3;
  localparam logic [2:0] KIND_ACCESS    = 3'd4;
  localparam logic [2:0] KIND_FIRST_BAD = 3'd5;
  localparam logic [2:0] KIND_TOP       = 3'd7;
  localparam logic [2:0] MODE_CONTROL   = 3'd0;

  localparam int BREAK_SLOTS    = 16;
  localparam int WATCH_SLOTS    = 16;
  localparam int PHASES         = 9;
  localparam int PHASE_WORDS    = 160;
  localparam int POOL           = 8;
  // longest remove: full scan plus full shift of 16 entries, with margin
  localparam int TAIL_CYCLES    = 80;
  // worst quiet stretch is a send gap plus the longest remove plus a receive stall
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {
    OP_WORD,  // one stream word
    OP_CFG,   // register write, issued once the block has drained
    OP_HOLD   // hold off until every result is back
  } op_e;

  typedef struct {
    op_e         op;
    cmd_e        cmd;
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [31:0] len;
    logic [3:0]  core;
    logic        cfg_idx;
    logic [4:0]  cfg_val;
    int          gap;
  } pend_t;

  // result word, status in the low bits
  typedef struct packed {
    logic [4:0] watch_count;
    logic [4:0] break_count;
    logic       stop;
    logic [1:0] status;
  } res_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;  // address[31:0], length[63:32], core_id[67:64], zero pad
  logic [4:0]  s_axis_tuser  = '0;  // command[1:0], point_kind[4:2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // status[1:0], stop[2], break_count[7:3],
                                    // watch_count[12:8], zero pad
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [4:0]  cfg_data_i    = '0;

  always #6 clk_i = ~clk_i;

  debug_breakpoint_table i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Shadow table: our own copy of both lists and of the two registers.
  // --------------------------------------------------------------------------
  logic [31:0] brk_addr [BREAK_SLOTS];
  logic [31:0] wch_begin[WATCH_SLOTS];
  logic [31:0] wch_end  [WATCH_SLOTS];
  logic [2:0]  wch_kind [WATCH_SLOTS];
  int          brk_cnt = 0;
  int          wch_cnt = 0;
  logic [2:0]  mode_r  = MODE_DETACH;
  logic [4:0]  sel_r   = SEL_ANY;

  // Applies one accepted word to the shadow table, returns the word it must produce.
  function automatic res_t table_outcome(input pend_t w);
    res_t        r;
    int          hit;
    logic [31:0] w_end;
    r     = '0;
    hit   = -1;
    w_end = w.addr + w.len;  // wraps at 32 bits
    case (w.cmd)
      CMD_INSERT: begin
        if (w.kind <= KIND_LAST_BREAK) begin
          if (brk_cnt >= BREAK_SLOTS) begin
            r.status = ST_FULL;
          end else begin
            brk_addr[brk_cnt] = w.addr;
            brk_cnt++;
          end
        end else if (w.kind <= KIND_LAST_WATCH) begin
          if (wch_cnt >= WATCH_SLOTS) begin
            r.status = ST_FULL;
          end else begin
            wch_begin[wch_cnt] = w.addr;
            wch_end[wch_cnt]   = w_end;
            wch_kind[wch_cnt]  = w.kind;
            wch_cnt++;
          end
        end else begin
          r.status = ST_BAD_KIND;
        end
      end
      CMD_REMOVE: begin
        // first exact match goes, later entries slide down; a miss is still OK
        if (w.kind <= KIND_LAST_BREAK) begin
          for (int i = 0; i < brk_cnt; i++)
            if (hit < 0 && brk_addr[i] == w.addr) hit = i;
          if (hit >= 0) begin
            for (int i = hit; i < brk_cnt - 1; i++) brk_addr[i] = brk_addr[i + 1];
            brk_cnt--;
          end
        end else if (w.kind <= KIND_LAST_WATCH) begin
          for (int i = 0; i < wch_cnt; i++)
            if (hit < 0 && wch_begin[i] == w.addr && wch_end[i] == w_end &&
                wch_kind[i] == w.kind) hit = i;
          if (hit >= 0) begin
            for (int i = hit; i < wch_cnt - 1; i++) begin
              wch_begin[i] = wch_begin[i + 1];
              wch_end[i]   = wch_end[i + 1];
              wch_kind[i]  = wch_kind[i + 1];
            end
            wch_cnt--;
          end
        end else begin
          r.status = ST_BAD_KIND;
        end
      end
      CMD_CLEAR: begin
        brk_cnt = 0;
        wch_cnt = 0;
      end
      default: begin
        // detach never stops; a selected core other than this one never stops;
        // step and init stop any permitted core; otherwise a breakpoint hit stops
        if (mode_r == MODE_DETACH) begin
          r.stop = 1'b0;
        end else if (sel_r != SEL_ANY && sel_r != {1'b0, w.core}) begin
          r.stop = 1'b0;
        end else if (mode_r == MODE_STEP || mode_r == MODE_INIT) begin
          r.stop = 1'b1;
        end else begin
          for (int i = 0; i < brk_cnt; i++)
            if (brk_addr[i] == w.addr) r.stop = 1'b1;
        end
      end
    endcase
    r.break_count = 5'(brk_cnt);
    r.watch_count = 5'(wch_cnt);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Pending work, filled up front by the stimulus block.
  // --------------------------------------------------------------------------
  pend_t pending_q[$];
  res_t  outcome_q[$];
  int    words_sent    = 0;  // words accepted by the block
  int    words_checked = 0;  // result words matched against an expectation
  int    mismatches    = 0;
  bit    send_quiet    = 1'b0;
  bit    recv_quiet    = 1'b0;

  task automatic push_word(input cmd_e cmd, input logic [2:0] kind, input logic [31:0] addr,
                           input logic [31:0] len, input logic [3:0] core);
    pend_t w;
    // toggle now and then between gappy traffic and back-to-back words
    if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
    w.op      = OP_WORD;
    w.cmd     = cmd;
    w.kind    = kind;
    w.addr    = addr;
    w.len     = len;
    w.core    = core;
    w.cfg_idx = 1'b0;
    w.cfg_val = '0;
    w.gap     = send_quiet ? 0 : $urandom_range(0, 16);
    pending_q.push_back(w);
  endtask

  task automatic push_ctrl(input op_e op, input logic idx, input logic [4:0] val);
    pend_t w;
    w.op      = op;
    w.cmd     = CMD_CHECK;
    w.kind    = '0;
    w.addr    = '0;
    w.len     = '0;
    w.core    = '0;
    w.cfg_idx = idx;
    w.cfg_val = val;
    w.gap     = 0;
    pending_q.push_back(w);
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents words, issues register writes once the block is drained.
  // --------------------------------------------------------------------------
  pend_t cur_word;
  bit    armed    = 1'b0;
  int    gap_left = 0;

  always @(posedge clk_i) begin
    logic  nxt_valid;
    logic  nxt_we;
    logic  took;
    pend_t head;
    nxt_valid = s_axis_tvalid;
    nxt_we    = 1'b0;
    took      = s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (took) begin
        outcome_q.push_back(table_outcome(cur_word));
        words_sent <= words_sent + 1;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_q.size() > 0) begin
        head = pending_q[0];
        if (!armed) begin
          gap_left = head.gap;
          armed    = 1'b1;
        end
        if (head.op == OP_WORD) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            pending_q.delete(0);
            armed     = 1'b0;
            cur_word  = head;
            nxt_valid = 1'b1;
            s_axis_tdata <= {4'b0, head.core, head.len, head.addr};
            s_axis_tuser <= {head.kind, head.cmd};
          end
        end else if (!took && words_checked == words_sent) begin
          // nothing in flight: safe to touch the registers
          pending_q.delete(0);
          armed = 1'b0;
          if (head.op == OP_CFG) begin
            nxt_we = 1'b1;
            cfg_idx_i  <= head.cfg_idx;
            cfg_data_i <= head.cfg_val;
            if (head.cfg_idx == REG_RUN_MODE) mode_r = head.cfg_val[2:0];
            else sel_r = head.cfg_val;
          end
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
    cfg_we_i      <= nxt_we;
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, checks each result word in order.
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    int   stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[12:0]);
      if (words_checked >= words_sent) begin
        $display("%0t: result word %h with nothing expected", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        words_checked <= words_checked + 1;
        if (got.status != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          mismatches++;
        end
        if (got.stop != want.stop) begin
          $display("%0t: stop expected %0d actual %0d", $time, want.stop, got.stop);
          mismatches++;
        end
        if (got.break_count != want.break_count) begin
          $display("%0t: break_count expected %0d actual %0d", $time,
                   want.break_count, got.break_count);
          mismatches++;
        end
        if (got.watch_count != want.watch_count) begin
          $display("%0t: watch_count expected %0d actual %0d", $time,
                   want.watch_count, got.watch_count);
          mismatches++;
        end
      end
      if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
      stall = recv_quiet ? 0 : $urandom_range(0, 16);
      stall_left    <= stall;
      m_axis_tready <= (stall == 0);
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any handshake or register write ends the run.
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** debug_breakpoint_table: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  logic [2:0]  mode_tab[PHASES] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0};
  int          sel_tab [PHASES] = '{-1, 15, 0, -1, -1, -16, 7, -2, -1};
  logic [31:0] brk_pool[POOL];
  logic [31:0] wch_addr[POOL];
  logic [31:0] wch_len [POOL];
  logic [2:0]  wch_pk  [POOL];

  initial begin
    int          ins_pct;
    int          r;
    int          p;
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [31:0] len;
    logic [3:0]  core;
    cmd_e        cmd;

    // reset values first: detach mode, so nothing stops even on a hit
    push_word(CMD_CHECK,  KIND_SW_BREAK, 32'h0, 32'h0, 4'd0);
    push_word(CMD_INSERT, KIND_SW_BREAK, 32'h0, 32'hFFFF_FFFF, 4'd15);
    push_word(CMD_CHECK,  KIND_TOP,      32'h0, 32'h0, 4'd15);
    push_ctrl(OP_CFG, REG_RUN_MODE, {2'b0, MODE_CONTROL});
    push_ctrl(OP_CFG, REG_SEL_CPU, SEL_ANY);
    push_word(CMD_CHECK,  KIND_SW_BREAK, 32'h0, 32'h0, 4'd15);
    push_word(CMD_INSERT, KIND_HW_BREAK, 32'hFFFF_FFFF, 32'h0, 4'd0);
    push_word(CMD_CHECK,  KIND_SW_BREAK, 32'hFFFF_FFFF, 32'h0, 4'd7);
    push_word(CMD_CHECK,  KIND_SW_BREAK, 32'h1234_5678, 32'h0, 4'd7);
    // watchpoints: end wrapping past 2^32, full length, zero length
    push_word(CMD_INSERT, KIND_WRITE,  32'hFFFF_FFF0, 32'h20, 4'd0);
    push_word(CMD_INSERT, KIND_READ,   32'h0, 32'hFFFF_FFFF, 4'd0);
    push_word(CMD_INSERT, KIND_ACCESS, 32'h1000, 32'h0, 4'd0);
    // unsupported kinds on insert and remove
    push_word(CMD_INSERT, KIND_FIRST_BAD, 32'h1000, 32'h4, 4'd0);
    push_word(CMD_INSERT, KIND_TOP,       32'h0, 32'h0, 4'd0);
    push_word(CMD_REMOVE, KIND_TOP - 3'd1, 32'hFFFF_FFFF, 32'h0, 4'd0);
    // missing break, watch with wrong type, then real removals with shift-down
    push_word(CMD_REMOVE, KIND_SW_BREAK, 32'hDEAD_0000, 32'h0, 4'd0);
    push_word(CMD_REMOVE, KIND_READ,     32'hFFFF_FFF0, 32'h20, 4'd0);
    push_word(CMD_REMOVE, KIND_WRITE,    32'hFFFF_FFF0, 32'h20, 4'd0);
    push_word(CMD_REMOVE, KIND_HW_BREAK, 32'h0, 32'h0, 4'd0);
    push_word(CMD_CHECK,  KIND_SW_BREAK, 32'h0, 32'h0, 4'd3);
    push_word(CMD_CHECK,  KIND_SW_BREAK, 32'hFFFF_FFFF, 32'h0, 4'd3);
    // clear ignores the kind
    push_word(CMD_CLEAR,  KIND_TOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    push_word(CMD_CHECK,  KIND_SW_BREAK, 32'hFFFF_FFFF, 32'h0, 4'd3);
    // step with one selected core, then a negative selection that never matches
    push_ctrl(OP_CFG, REG_RUN_MODE, {2'b0, MODE_STEP});
    push_ctrl(OP_CFG, REG_SEL_CPU, 5'd5);
    push_word(CMD_CHECK, KIND_SW_BREAK, 32'h40, 32'h0, 4'd5);
    push_word(CMD_CHECK, KIND_SW_BREAK, 32'h40, 32'h0, 4'd4);
    push_ctrl(OP_CFG, REG_SEL_CPU, 5'h10);
    push_word(CMD_CHECK, KIND_SW_BREAK, 32'h40, 32'h0, 4'd0);
    push_ctrl(OP_CFG, REG_RUN_MODE, {2'b0, MODE_INIT});
    push_ctrl(OP_CFG, REG_SEL_CPU, SEL_ANY);
    push_word(CMD_CHECK, KIND_SW_BREAK, 32'h40, 32'h0, 4'd9);
    push_ctrl(OP_HOLD, REG_RUN_MODE, '0);

    // random phases: each with its own register setting and address pools,
    // every third one insert-heavy so both lists run full
    for (int ph = 0; ph < PHASES; ph++) begin
      push_ctrl(OP_CFG, REG_RUN_MODE, {2'b0, mode_tab[ph]});
      push_ctrl(OP_CFG, REG_SEL_CPU, 5'(sel_tab[ph]));
      ins_pct = (ph % 3 == 0) ? 55 : 30;
      for (int i = 0; i < POOL; i++) begin
        brk_pool[i] = $urandom;
        wch_addr[i] = $urandom;
        wch_len[i]  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 64) : $urandom;
        wch_pk[i]   = $urandom_range(KIND_WRITE, KIND_ACCESS);
      end
      brk_pool[0] = 32'h0;
      brk_pool[1] = 32'hFFFF_FFFF;
      wch_addr[0] = 32'hFFFF_FFFF;
      wch_len[0]  = 32'hFFFF_FFFF;
      wch_len[1]  = 32'h0;

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph % 2 == 1 && n == PHASE_WORDS / 2) push_ctrl(OP_HOLD, REG_RUN_MODE, '0);
        r    = $urandom_range(0, 99);
        kind = $urandom_range(0, 7);
        addr = $urandom;
        len  = $urandom;
        core = $urandom_range(0, 15);
        p    = $urandom_range(0, POOL - 1);
        if (r < ins_pct + 20) begin
          cmd = (r < ins_pct) ? CMD_INSERT : CMD_REMOVE;
          // mostly pool entries so removes find what was inserted; rest is noise
          if ($urandom_range(0, 6) != 0) begin
            kind = $urandom_range(KIND_SW_BREAK, KIND_ACCESS);
            if (kind <= KIND_LAST_BREAK) begin
              addr = brk_pool[p];
            end else begin
              addr = wch_addr[p];
              len  = wch_len[p];
              kind = wch_pk[p];
              // near miss on remove: same begin, other end or type
              if (cmd == CMD_REMOVE && $urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 1) == 0) len = len ^ (32'h1 << $urandom_range(0, 31));
                else kind = (kind == KIND_ACCESS) ? KIND_WRITE : kind + 3'd1;
              end
            end
          end
        end else if (r < ins_pct + 22) begin
          cmd = CMD_CLEAR;
        end else begin
          cmd = CMD_CHECK;
          if ($urandom_range(0, 3) != 0) addr = brk_pool[p];
          if (sel_tab[ph] >= 0 && $urandom_range(0, 1) == 0) core = 4'(sel_tab[ph]);
        end
        push_word(cmd, kind, addr, len, core);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample at the falling edge so the driver's updates have settled
    do @(negedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || words_checked != words_sent);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("** debug_breakpoint_table: PASSED **");
    end else begin
      $display("** debug_breakpoint_table: FAILED **");
    end
    $finish;
  end

endmodule
